FILE: hdl/oprt_pkg.sv
// Package for the ordered prefix route table.
// Holds the command and status codes, the stored route layout and the
// command record. No dependencies.
package oprt_pkg;

  localparam int unsigned ENTRIES = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DEL    = 2'd1,
    CMD_IFDEL  = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOSUCH  = 2'd2,
    ST_NOROUTE = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] prefix_hi;
    logic [63:0] prefix_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic [63:0] hop_hi;
    logic [63:0] hop_lo;
    logic [7:0]  iface;
    logic [7:0]  flags;
  } route_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic        mask_given;
    logic [63:0] hop_hi;
    logic [63:0] hop_lo;
    logic [7:0]  iface;
    logic [7:0]  route_flags;
  } req_t;

endpackage

FILE: hdl/oprt_if.sv
// Valid/ready channel interfaces for the route table command and result.
// No dependencies.
interface oprt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [63:0] mask_hi;
  logic [63:0] mask_lo;
  logic        mask_given;
  logic [63:0] hop_hi;
  logic [63:0] hop_lo;
  logic [7:0]  iface;
  logic [7:0]  route_flags;

  modport source (output valid, cmd, addr_hi, addr_lo, mask_hi, mask_lo, mask_given,
                  hop_hi, hop_lo, iface, route_flags, input ready);
  modport sink (input valid, cmd, addr_hi, addr_lo, mask_hi, mask_lo, mask_given,
                hop_hi, hop_lo, iface, route_flags, output ready);
endinterface

interface oprt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_iface;
  logic [63:0] out_hop_hi;
  logic [63:0] out_hop_lo;

  modport source (output valid, status, out_iface, out_hop_hi, out_hop_lo, input ready);
  modport sink (input valid, status, out_iface, out_hop_hi, out_hop_lo, output ready);
endinterface

FILE: hdl/oprt_ram.sv
// Generic simple dual-port RAM: one write port, one read port,
// registered read data. No dependencies.
module oprt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

FILE: hdl/ordered_prefix_route_table.sv
// Top level of the ordered prefix route table.
// Depends on oprt_pkg, oprt_if.sv and oprt_ram.
//
// Usage:
//   cmd_i takes one command per transfer: add, delete, delete by interface
//   or lookup. res_o gives exactly one result per command, in order.
//   Routes live in one RAM, kept physically in match order: the most
//   specific masks first, equal masks in arrival order.
//   A command scans the stored routes one at a time, each with a RAM read
//   and then a compare. An add that lands in front of others and a
//   delete move the tail by one place, each moved route with a RAM read
//   and then a write. Scanned plus moved routes never exceed ENTRIES.
//   Commands are taken one at a time; the next one is taken while a result
//   still waits in the output register. A stalled receiver holds the
//   result and stops the block only when the next result is ready.
//   Reset empties the table at once (route count to zero); no clearing pass.
module ordered_prefix_route_table #(
  parameter int unsigned Entries = oprt_pkg::ENTRIES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oprt_cmd_if.sink   cmd_i,
  oprt_res_if.source res_o
);
  import oprt_pkg::*;

  localparam int unsigned IW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CW = $clog2(Entries + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_MRD, S_MWR, S_INS, S_DONE
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [IW-1:0]   idx_q, pos_q, mv_q;
  logic [CW-1:0]   wj_q;
  req_t            req_q;
  status_e         st_q;
  logic [7:0]      oif_q;
  logic [63:0]     ohh_q, ohl_q;
  logic            out_valid_q;
  status_e         out_st_q;
  logic [7:0]      out_if_q;
  logic [63:0]     out_hh_q, out_hl_q;

  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  route_t          ram_wdata, rd_route, new_route;

  logic            last, add_stop, del_hit, keep, lk_hit, direct;

  oprt_ram #(.Width($bits(route_t)), .Depth(Entries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_route)
  );

  assign new_route = '{prefix_hi: req_q.addr_hi & req_q.mask_hi,
                       prefix_lo: req_q.addr_lo & req_q.mask_lo,
                       mask_hi: req_q.mask_hi, mask_lo: req_q.mask_lo,
                       hop_hi: req_q.hop_hi, hop_lo: req_q.hop_lo,
                       iface: req_q.iface, flags: req_q.route_flags};

  assign last     = (CW'(idx_q) + CW'(1)) == count_q;
  assign add_stop = |((req_q.mask_hi & ~rd_route.mask_hi) |
                      (req_q.mask_lo & ~rd_route.mask_lo));
  assign del_hit  = (rd_route.prefix_hi == req_q.addr_hi) &&
                    (rd_route.prefix_lo == req_q.addr_lo) &&
                    (!req_q.mask_given || ((rd_route.mask_hi == req_q.mask_hi) &&
                                           (rd_route.mask_lo == req_q.mask_lo))) &&
                    (((rd_route.hop_hi == req_q.hop_hi) &&
                      (rd_route.hop_lo == req_q.hop_lo)) ||
                     (rd_route.iface == req_q.iface));
  assign keep     = rd_route.iface != req_q.iface;
  assign lk_hit   = ((req_q.addr_hi & rd_route.mask_hi) == rd_route.prefix_hi) &&
                    ((req_q.addr_lo & rd_route.mask_lo) == rd_route.prefix_lo);
  assign direct   = (rd_route.hop_hi | rd_route.hop_lo) == 64'd0;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    ram_we    = 1'b0;
    ram_waddr = mv_q;
    ram_wdata = rd_route;
    case (state_q)
      S_RD: begin
        ram_re = 1'b1;
      end
      S_MRD: begin
        ram_re    = 1'b1;
        ram_raddr = (req_q.cmd == CMD_ADD) ? mv_q - IW'(1) : mv_q + IW'(1);
      end
      S_MWR: begin
        ram_we = 1'b1;
      end
      S_EV: begin
        if (req_q.cmd == CMD_IFDEL && keep) begin
          ram_we    = 1'b1;
          ram_waddr = wj_q[IW-1:0];
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = new_route;
      end
      default: ;
    endcase
  end

  assign cmd_i.ready      = state_q == S_IDLE;
  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_st_q;
  assign res_o.out_iface  = out_if_q;
  assign res_o.out_hop_hi = out_hh_q;
  assign res_o.out_hop_lo = out_hl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      mv_q        <= '0;
      wj_q        <= '0;
      req_q       <= '0;
      st_q        <= ST_OK;
      oif_q       <= '0;
      ohh_q       <= '0;
      ohl_q       <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_if_q    <= '0;
      out_hh_q    <= '0;
      out_hl_q    <= '0;
    end else begin
      if (res_o.valid && res_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            req_q <= '{cmd: cmd_i.cmd, addr_hi: cmd_i.addr_hi, addr_lo: cmd_i.addr_lo,
                       mask_hi: cmd_i.mask_hi, mask_lo: cmd_i.mask_lo,
                       mask_given: cmd_i.mask_given, hop_hi: cmd_i.hop_hi,
                       hop_lo: cmd_i.hop_lo, iface: cmd_i.iface,
                       route_flags: cmd_i.route_flags};
            idx_q <= '0;
            pos_q <= '0;
            wj_q  <= '0;
            oif_q <= '0;
            ohh_q <= '0;
            ohl_q <= '0;
            st_q  <= ST_OK;
            if (cmd_i.cmd == CMD_ADD && count_q == CW'(Entries)) begin
              st_q    <= ST_FULL;
              state_q <= S_DONE;
            end else if (count_q == '0) begin
              unique case (cmd_e'(cmd_i.cmd))
                CMD_ADD:    state_q <= S_INS;
                CMD_DEL:    begin st_q <= ST_NOSUCH;  state_q <= S_DONE; end
                CMD_IFDEL:  state_q <= S_DONE;
                CMD_LOOKUP: begin st_q <= ST_NOROUTE; state_q <= S_DONE; end
              endcase
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_EV;
        end
        S_EV: begin
          state_q <= S_RD;
          idx_q   <= idx_q + IW'(1);
          unique case (cmd_e'(req_q.cmd))
            CMD_ADD: begin
              if (add_stop) begin
                pos_q   <= idx_q;
                mv_q    <= count_q[IW-1:0];
                state_q <= S_MRD;
              end else if (last) begin
                pos_q   <= count_q[IW-1:0];
                state_q <= S_INS;
              end
            end
            CMD_DEL: begin
              if (del_hit) begin
                if (last) begin
                  count_q <= count_q - CW'(1);
                  state_q <= S_DONE;
                end else begin
                  mv_q    <= idx_q;
                  state_q <= S_MRD;
                end
              end else if (last) begin
                st_q    <= ST_NOSUCH;
                state_q <= S_DONE;
              end
            end
            CMD_IFDEL: begin
              if (keep) begin
                wj_q <= wj_q + CW'(1);
              end
              if (last) begin
                count_q <= wj_q + CW'(keep);
                state_q <= S_DONE;
              end
            end
            CMD_LOOKUP: begin
              if (lk_hit) begin
                oif_q   <= rd_route.iface;
                ohh_q   <= direct ? req_q.addr_hi : rd_route.hop_hi;
                ohl_q   <= direct ? req_q.addr_lo : rd_route.hop_lo;
                state_q <= S_DONE;
              end else if (last) begin
                st_q    <= ST_NOROUTE;
                state_q <= S_DONE;
              end
            end
          endcase
        end
        S_MRD: begin
          state_q <= S_MWR;
        end
        S_MWR: begin
          state_q <= S_MRD;
          if (req_q.cmd == CMD_ADD) begin
            mv_q <= mv_q - IW'(1);
            if (mv_q - IW'(1) == pos_q) begin
              state_q <= S_INS;
            end
          end else begin
            mv_q <= mv_q + IW'(1);
            if (CW'(mv_q) + CW'(2) == count_q) begin
              count_q <= count_q - CW'(1);
              state_q <= S_DONE;
            end
          end
        end
        S_INS: begin
          count_q <= count_q + CW'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_st_q    <= st_q;
            out_if_q    <= oif_q;
            out_hh_q    <= ohh_q;
            out_hl_q    <= ohl_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule
